/* rtl/sitda_pkg.sv */
// Shared constants and control/status types for the integer-to-decimal text unit.
`default_nettype none

package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int CHAR_W     = 6;

    localparam logic [CNT_W-1:0]  LAST_SHIFT = CNT_W'(VALUE_W - 1);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture sign and magnitude of a new value
        logic shift;      // one shift-and-add-3 conversion step
        logic emit_sign;  // output mux selects the minus sign
        logic digit_adv;  // step to the next lower digit
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic negative;   // value being converted is negative
        logic conv_done;  // current shift step is the final one
        logic digit_last; // current digit is the least significant
    } t_stat;

endpackage

`default_nettype wire

/* rtl/sitda_dp.sv */
// Datapath: double-dabble binary-to-BCD converter and character output mux.
`default_nettype none

module sitda_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  signed [sitda_pkg::VALUE_W-1:0] i_value,
    input  wire  sitda_pkg::t_cmd            i_cmd,
    output sitda_pkg::t_stat                 o_stat,
    output logic [sitda_pkg::CHAR_W-1:0]     o_character
);

    logic [sitda_pkg::VALUE_W-1:0] r_bin;
    logic [sitda_pkg::BCD_W-1:0]   r_bcd;
    logic                          r_neg;
    logic [sitda_pkg::CNT_W-1:0]   r_cnt;
    logic [sitda_pkg::IDX_W-1:0]   r_idx;

    logic [sitda_pkg::BCD_W-1:0]   n_bcd;
    logic [sitda_pkg::BCD_W-1:0]   adj_bcd;
    logic [sitda_pkg::IDX_W-1:0]   n_msd;
    logic [sitda_pkg::VALUE_W-1:0] raw;
    logic [3:0]                    cur_digit;

    assign raw = i_value;

    // Add 3 to every digit of 5 or more, then shift in the next magnitude bit
    always_comb begin
        for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj_bcd[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj_bcd[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
        n_bcd = {adj_bcd[sitda_pkg::BCD_W-2:0], r_bin[sitda_pkg::VALUE_W-1]};
    end

    // Most significant nonzero digit of the next BCD value; zero gives digit 0
    always_comb begin
        n_msd = '0;
        for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
            if (n_bcd[4*i +: 4] != 4'd0) begin
                n_msd = sitda_pkg::IDX_W'(i);
            end
        end
    end

    // Conversion registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.shift) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= raw[sitda_pkg::VALUE_W-1];
            r_bin <= raw[sitda_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
            r_bcd <= '0;
        end else if (i_cmd.shift) begin
            r_bin <= {r_bin[sitda_pkg::VALUE_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

    // Digit pointer: set to the leading digit on each step, counts down on emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_idx <= n_msd;
        end else if (i_cmd.digit_adv) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    assign cur_digit = r_bcd[{r_idx, 2'b00} +: 4];

    always_comb begin
        o_stat.negative   = r_neg;
        o_stat.conv_done  = (r_cnt == sitda_pkg::LAST_SHIFT);
        o_stat.digit_last = (r_idx == '0);
        o_character = i_cmd.emit_sign ? sitda_pkg::CHAR_MINUS
                                      : sitda_pkg::CHAR_ZERO + {2'b00, cur_digit};
    end

endmodule

`default_nettype wire

/* rtl/sitda_ctrl.sv */
// Controller: sequences load, conversion steps and character emission.
`default_nettype none

module sitda_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  wire               i_ready,
    output logic              o_last,
    input  wire  sitda_pkg::t_stat i_stat,
    output sitda_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_SIGN  = 2'd2;
    localparam logic [1:0] S_DIGIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       out_take;

    assign out_take = o_valid && i_ready;

    // Next state and command decode
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_ready       = 1'b0;
        o_valid       = 1'b0;
        o_last        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready   = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_stat.conv_done) begin
                    n_state = i_stat.negative ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                o_valid        = 1'b1;
                o_cmd.emit_sign = 1'b1;
                if (out_take) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                o_valid = 1'b1;
                o_last  = i_stat.digit_last;
                if (out_take) begin
                    if (i_stat.digit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.digit_adv = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/signed_int_to_decimal_ascii_unit.sv */
// Top level: signed 32-bit integer to decimal ASCII text, one character per word.
//
// Input channel (i_valid/o_ready) takes one signed 32-bit value per word.
// Output channel (o_valid/i_ready) returns its decimal text, most significant
// character first: a minus sign for negative values, then the digits with no
// leading zeros (zero gives a single '0'). o_last marks the final character.
// A value yields 1 to 11 output words.
//
// One value is handled at a time. After acceptance the magnitude goes through
// 32 double-dabble steps, one per cycle, in a single shared add-3/shift unit;
// the first character appears once the final step is done. Characters then
// leave at one per cycle while the receiver is ready, and the next value can
// be accepted only after the final character has been taken. o_ready is high
// only while the unit is idle.
//
// When the receiver holds i_ready low, the current character and o_last stay
// stable and the unit waits. Synchronous active-low reset returns the unit to
// idle and discards any value in progress.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  signed [sitda_pkg::VALUE_W-1:0] i_value,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [sitda_pkg::CHAR_W-1:0]         o_character,
    output logic                                 o_last
);

    sitda_pkg::t_cmd  cmd;
    sitda_pkg::t_stat stat;

    sitda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_last  (o_last),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sitda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_character (o_character)
    );

    // Input and output sides are never open at the same time
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while an output word is pending");

    // An accepted value is never answered in the next cycle
    a_conv_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid)
        else $error("output word right after input acceptance");

    // Taking the last character frees the input side
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> o_ready)
        else $error("unit not idle after final character");

    // A minus sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_character == sitda_pkg::CHAR_MINUS) |-> !o_last)
        else $error("minus sign flagged as last character");

endmodule

`default_nettype wire
